@@ src/wcl_pkg.sv @@
// Package: shared types and constants of the wheel command line parser.
`default_nettype none
package wcl_pkg;
	localparam int LINE_BUFFER_BYTES = 64;
	localparam int LEN_W = 7;
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_BYTES - 1);

	localparam logic [2:0] EV_TARGETS = 3'd0;
	localparam logic [2:0] EV_STOP = 3'd1;
	localparam logic [2:0] EV_QUERY = 3'd2;
	localparam logic [2:0] EV_BAD = 3'd3;
	localparam logic [2:0] EV_UNKNOWN = 3'd4;
	localparam logic [2:0] EV_OVERFLOW = 3'd5;

	localparam logic [3:0] PH_LEAD = 4'd0;
	localparam logic [3:0] PH_S = 4'd1;
	localparam logic [3:0] PH_Q = 4'd2;
	localparam logic [3:0] PH_UNK = 4'd3;
	localparam logic [3:0] PH_SEP = 4'd4;
	localparam logic [3:0] PH_WS = 4'd5;
	localparam logic [3:0] PH_SIGN = 4'd6;
	localparam logic [3:0] PH_DIG = 4'd7;
	localparam logic [3:0] PH_TRAIL = 4'd8;
	localparam logic [3:0] PH_BAD = 4'd9;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] t0;
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
	} event_t;
endpackage
`default_nettype wire

@@ src/wcl_front.sv @@
// Front end: per-byte line parser that emits one event item per finished line.
`default_nettype none
module wcl_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire logic take,
	input  wire logic [14:0] max_rpm,
	output wcl_pkg::event_t ev,
	output logic ev_valid
);
	logic [wcl_pkg::LEN_W-1:0] len_q;
	logic [3:0] phase_q;
	logic [2:0] widx_q;
	logic [15:0] acc_q;
	logic neg_q;
	logic ended_q;
	logic [15:0] tgt_q [4];

	logic is_eol, is_dig, is_sep, is_vtff, is_pm;
	logic [3:0] dval;
	logic [19:0] prod;
	logic [15:0] acc_sat, clamped, signed_mag;

	assign is_eol = (rx_byte == 8'd10) || (rx_byte == 8'd13);
	assign is_dig = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
	assign is_sep = (rx_byte == 8'h2c) || (rx_byte == 8'h20) || (rx_byte == 8'h09);
	assign is_vtff = (rx_byte == 8'd11) || (rx_byte == 8'd12);
	assign is_pm = (rx_byte == 8'h2b) || (rx_byte == 8'h2d);
	assign dval = rx_byte[3:0];
	// acc*10 + d, saturated at 16 bits
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 20'(dval);
	assign acc_sat = (prod > 20'hFFFF) ? 16'hFFFF : prod[15:0];
	assign clamped = (acc_q > {1'b0, max_rpm}) ? {1'b0, max_rpm} : acc_q;
	assign signed_mag = neg_q ? (16'd0 - clamped) : clamped;

	logic [3:0] ph_n;
	logic [2:0] widx_n;
	logic [15:0] acc_n;
	logic neg_n, fin;

	// parse step for a non-terminator byte
	always_comb begin
		logic wait_sep;
		wait_sep = 1'b0;
		ph_n = phase_q;
		widx_n = widx_q;
		acc_n = acc_q;
		neg_n = neg_q;
		fin = 1'b0;
		unique case (phase_q)
			wcl_pkg::PH_LEAD: begin
				if (rx_byte == 8'h20 || rx_byte == 8'h09) ph_n = phase_q;
				else if (rx_byte == 8'h54 || rx_byte == 8'h74) ph_n = wcl_pkg::PH_SEP;
				else if (rx_byte == 8'h53 || rx_byte == 8'h73) ph_n = wcl_pkg::PH_S;
				else if (rx_byte == 8'h51 || rx_byte == 8'h71) ph_n = wcl_pkg::PH_Q;
				else ph_n = wcl_pkg::PH_UNK;
			end
			wcl_pkg::PH_S, wcl_pkg::PH_Q: ph_n = wcl_pkg::PH_UNK;
			wcl_pkg::PH_SEP: wait_sep = 1'b1;
			wcl_pkg::PH_WS: begin
				if (rx_byte == 8'h20 || rx_byte == 8'h09 || is_vtff) ph_n = phase_q;
				else if (is_pm || is_dig) begin
					ph_n = is_dig ? wcl_pkg::PH_DIG : wcl_pkg::PH_SIGN;
					neg_n = (rx_byte == 8'h2d);
					acc_n = {12'd0, dval};
				end else ph_n = wcl_pkg::PH_BAD;
			end
			wcl_pkg::PH_SIGN: begin
				if (is_dig) begin
					acc_n = {12'd0, dval};
					ph_n = wcl_pkg::PH_DIG;
				end else ph_n = wcl_pkg::PH_BAD;
			end
			wcl_pkg::PH_DIG: begin
				if (is_dig) acc_n = acc_sat;
				else begin
					fin = 1'b1;
					widx_n = widx_q + 3'd1;
					acc_n = '0;
					neg_n = 1'b0;
					wait_sep = 1'b1;
				end
			end
			wcl_pkg::PH_TRAIL: if (!is_sep) ph_n = wcl_pkg::PH_BAD;
			default: ph_n = phase_q;
		endcase
		if (wait_sep) begin
			if (widx_n >= 3'd4) ph_n = is_sep ? wcl_pkg::PH_TRAIL : wcl_pkg::PH_BAD;
			else if (is_sep) ph_n = wcl_pkg::PH_SEP;
			else if (is_vtff) ph_n = wcl_pkg::PH_WS;
			else if (is_pm || is_dig) begin
				ph_n = is_dig ? wcl_pkg::PH_DIG : wcl_pkg::PH_SIGN;
				neg_n = (rx_byte == 8'h2d);
				acc_n = {12'd0, dval};
			end else ph_n = wcl_pkg::PH_BAD;
		end
	end

	// event classification at end of line
	logic [2:0] eol_kind;
	always_comb begin
		unique case (phase_q)
			wcl_pkg::PH_S: eol_kind = wcl_pkg::EV_STOP;
			wcl_pkg::PH_Q: eol_kind = wcl_pkg::EV_QUERY;
			wcl_pkg::PH_LEAD, wcl_pkg::PH_UNK: eol_kind = wcl_pkg::EV_UNKNOWN;
			wcl_pkg::PH_DIG: eol_kind = (widx_q == 3'd3 || widx_q == 3'd7) ?
				wcl_pkg::EV_TARGETS : wcl_pkg::EV_BAD;
			wcl_pkg::PH_TRAIL: eol_kind = wcl_pkg::EV_TARGETS;
			default: eol_kind = wcl_pkg::EV_BAD;
		endcase
	end

	logic fire, over;
	assign over = !is_eol && (len_q >= wcl_pkg::LEN_LIMIT);
	assign fire = take && ((is_eol && len_q != '0) || over);

	// last number of the line lands in its slot as the event leaves
	logic [15:0] tg [4];
	always_comb begin
		for (int k = 0; k < 4; k++) tg[k] = tgt_q[k];
		if (phase_q == wcl_pkg::PH_DIG) tg[widx_q[1:0]] = signed_mag;
		ev.kind = over ? wcl_pkg::EV_OVERFLOW : eol_kind;
		ev.t0 = tg[0];
		ev.t1 = tg[1];
		ev.t2 = tg[2];
		ev.t3 = tg[3];
	end
	assign ev_valid = fire;

	always_ff @(posedge clk) begin
		if (take && !is_eol && !over && rx_byte != 8'd0 && !ended_q && fin)
			tgt_q[widx_q[1:0]] <= signed_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			phase_q <= wcl_pkg::PH_LEAD;
			widx_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			ended_q <= 1'b0;
		end else if (take) begin
			if (is_eol || over) begin
				len_q <= '0;
				phase_q <= wcl_pkg::PH_LEAD;
				widx_q <= '0;
				acc_q <= '0;
				neg_q <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				len_q <= len_q + 1'b1;
				if (rx_byte == 8'd0) ended_q <= 1'b1;
				else if (!ended_q) begin
					phase_q <= ph_n;
					widx_q <= widx_n;
					acc_q <= acc_n;
					neg_q <= neg_n;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ src/wcl_queue.sv @@
// Short event queue between the parser and the result stage.
`default_nettype none
module wcl_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire wcl_pkg::event_t wdata,
	input  wire logic rd,
	output wcl_pkg::event_t rdata,
	output logic full,
	output logic empty
);
	wcl_pkg::event_t mem_q [wcl_pkg::QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(wcl_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

@@ src/wcl_back.sv @@
// Back end: applies events to the remote flag and holds the result item.
`default_nettype none
module wcl_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire wcl_pkg::event_t ev,
	input  wire logic ev_empty,
	output logic ev_pop,
	input  wire logic pop,
	output logic empty,
	output logic [2:0] event_kind,
	output logic signed [15:0] target_front_left,
	output logic signed [15:0] target_front_right,
	output logic signed [15:0] target_rear_left,
	output logic signed [15:0] target_rear_right,
	output logic control_active
);
	logic full_q, active_q, act_n, tg;
	assign tg = (ev.kind == wcl_pkg::EV_TARGETS);
	assign ev_pop = !ev_empty && (!full_q || pop);
	assign empty = !full_q;
	assign act_n = tg ? 1'b1 : (ev.kind == wcl_pkg::EV_STOP) ? 1'b0 : active_q;

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			event_kind <= ev.kind;
			target_front_left <= tg ? ev.t0 : '0;
			target_front_right <= tg ? ev.t1 : '0;
			target_rear_left <= tg ? ev.t2 : '0;
			target_rear_right <= tg ? ev.t3 : '0;
			control_active <= act_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			active_q <= 1'b0;
		end else begin
			if (ev_pop) begin
				full_q <= 1'b1;
				active_q <= act_n;
			end else if (pop) full_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ src/wheel_command_line_parser_top.sv @@
// Top level of the wheel command line parser.
// Usage:
//  Input channel: drive rx_byte and raise push; the item is taken at a clock
//  edge where push is high and full is low. One byte per cycle is accepted.
//  Each byte updates the line parser at once; LF or CR finishing a non-empty
//  line (or any other byte after 63 bytes of it) makes one event item.
//  Result channel: while empty is low the oldest event sits on event_kind,
//  the four targets and control_active; pop takes it.
//  Path: the queue is written at the edge that takes the ending byte, and
//  the output register loads from the queue whenever that register is empty
//  or being popped, so the event reaches the result ports through both.
//  Throughput: one byte per cycle while full is low; the parser update
//  with its times-ten accumulate is combinational. A two-entry queue sits
//  ahead of the output register: full only rises with three events unpopped.
//  Stalls: with pop low the output register holds; the queue absorbs two more
//  events, then full goes high and bytes are refused.
//  Reset (arst_n low): line state cleared, queue and output emptied, the
//  remote flag cleared (not the control_active register), max_rpm back to
//  300. Target slots are not reset; each is written before a line reports it.
//  max_rpm is written by cfg_we/cfg_data and should only change while idle.
`default_nettype none
module wheel_command_line_parser_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [7:0] rx_byte,
	input  wire logic cfg_we,
	input  wire logic [14:0] cfg_data,
	input  wire logic pop,
	output logic empty,
	output logic [2:0] event_kind,
	output logic signed [15:0] target_front_left,
	output logic signed [15:0] target_front_right,
	output logic signed [15:0] target_rear_left,
	output logic signed [15:0] target_rear_right,
	output logic control_active
);
	logic [14:0] max_rpm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_rpm_q <= 15'd300;
		else if (cfg_we) max_rpm_q <= cfg_data;
	end

	wcl_pkg::event_t fev, qev;
	logic fvalid, take, qempty, qpop;
	assign take = push && !full;

	wcl_front u_front (
		.clk(clk), .arst_n(arst_n), .rx_byte(rx_byte), .take(take),
		.max_rpm(max_rpm_q), .ev(fev), .ev_valid(fvalid)
	);

	wcl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(fvalid), .wdata(fev), .rd(qpop),
		.rdata(qev), .full(full), .empty(qempty)
	);

	wcl_back u_back (
		.clk(clk), .arst_n(arst_n), .ev(qev), .ev_empty(qempty), .ev_pop(qpop),
		.pop(pop), .empty(empty), .event_kind(event_kind),
		.target_front_left(target_front_left),
		.target_front_right(target_front_right),
		.target_rear_left(target_rear_left),
		.target_rear_right(target_rear_right),
		.control_active(control_active)
	);

	// a target event always leaves control active
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == wcl_pkg::EV_TARGETS) |-> control_active)
		else $error("targets without control_active");
	// stop always clears it
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == wcl_pkg::EV_STOP) |-> !control_active)
		else $error("stop left control_active");
	// non-target events carry zero targets
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != wcl_pkg::EV_TARGETS) |->
		(target_front_left == 16'sd0 && target_rear_right == 16'sd0))
		else $error("stray targets");
	// a held result stays put while not popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_kind)))
		else $error("result changed under stall");
endmodule
`default_nettype wire
